[rtl/core/jdcw_pkg.sv]
// Shared types and constants for the Julian day calendar walker.
// Holds the microcode word layout, the control store and the month-length
// table. Depends on nothing.
package jdcw_pkg;

	// Calendar constants
	localparam logic [30:0]        JdReform       = 31'd2299161;
	localparam logic [31:0]        ReformSkip     = 32'd10;
	localparam logic signed [23:0] StartYear      = -24'sd4713;
	localparam logic signed [23:0] LastJulianYear = 24'sd1582;
	localparam logic [31:0]        GregCycleDays  = 32'd146097;
	localparam logic signed [23:0] GregCycleYears = 24'sd400;
	localparam logic [8:0]         Mod400Last     = 9'd399;
	localparam logic [8:0]         Century1       = 9'd100;
	localparam logic [8:0]         Century2       = 9'd200;
	localparam logic [8:0]         Century3       = 9'd300;
	localparam logic [8:0]         CommonYearDays = 9'd365;

	// Month codes
	localparam logic [3:0] MonthJan = 4'd1;
	localparam logic [3:0] MonthFeb = 4'd2;
	localparam logic [3:0] MonthApr = 4'd4;
	localparam logic [3:0] MonthJun = 4'd6;
	localparam logic [3:0] MonthSep = 4'd9;
	localparam logic [3:0] MonthNov = 4'd11;
	localparam logic [3:0] MonthDec = 4'd12;

	// Microcode step addresses
	typedef enum logic [3:0] {
		STEP_IDLE,
		STEP_CHECK,
		STEP_LOAD,
		STEP_LOOP,
		STEP_TRY_CYCLE,
		STEP_TRY_YEAR,
		STEP_TRY_MONTH,
		STEP_FINISH,
		STEP_EMIT
	} step_t;

	// Branch conditions
	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_IN_VALID,
		COND_BEHIND,
		COND_REM_ZERO,
		COND_CYCLE_OK,
		COND_YEAR_OK,
		COND_MONTH_OK,
		COND_OUT_FREE
	} cond_t;

	// Datapath operations, executed when the condition holds
	typedef enum logic [3:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_FLAG_ERR,
		OP_LOAD,
		OP_CYCLE,
		OP_YEAR,
		OP_MONTH,
		OP_DAY,
		OP_EMIT
	} op_t;

	typedef struct packed {
		cond_t cond;
		op_t   op;
		step_t jump_t;
		step_t jump_f;
	} ucode_t;

	// Control store: one word per step
	function automatic ucode_t ucode_rom(input step_t s);
		ucode_t w;
		unique case (s)
			STEP_IDLE:      w = '{COND_IN_VALID, OP_ACCEPT,   STEP_CHECK,     STEP_IDLE};
			STEP_CHECK:     w = '{COND_BEHIND,   OP_FLAG_ERR, STEP_EMIT,      STEP_LOAD};
			STEP_LOAD:      w = '{COND_ALWAYS,   OP_LOAD,     STEP_LOOP,      STEP_LOOP};
			STEP_LOOP:      w = '{COND_REM_ZERO, OP_NOP,      STEP_EMIT,      STEP_TRY_CYCLE};
			STEP_TRY_CYCLE: w = '{COND_CYCLE_OK, OP_CYCLE,    STEP_LOOP,      STEP_TRY_YEAR};
			STEP_TRY_YEAR:  w = '{COND_YEAR_OK,  OP_YEAR,     STEP_LOOP,      STEP_TRY_MONTH};
			STEP_TRY_MONTH: w = '{COND_MONTH_OK, OP_MONTH,    STEP_LOOP,      STEP_FINISH};
			STEP_FINISH:    w = '{COND_ALWAYS,   OP_DAY,      STEP_EMIT,      STEP_EMIT};
			STEP_EMIT:      w = '{COND_OUT_FREE, OP_EMIT,     STEP_IDLE,      STEP_EMIT};
			default:        w = '{COND_ALWAYS,   OP_NOP,      STEP_IDLE,      STEP_IDLE};
		endcase
		return w;
	endfunction

	// Days in a month; unknown month codes read as January
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] d;
		unique case (m) inside
			MonthFeb:                               d = 5'd28 + {4'b0, leap};
			MonthApr, MonthJun, MonthSep, MonthNov: d = 5'd30;
			default:                                d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

[rtl/core/jdcw_if.sv]
// Handshake channels of the Julian day calendar walker: the target day
// channel and the calendar date channel. Depends on nothing.
interface jdcw_target_if;
	logic        valid;
	logic        ready;
	logic [30:0] target_day;

	modport source(output valid, output target_day, input ready);
	modport sink(input valid, input target_day, output ready);
endinterface

interface jdcw_date_if;
	logic        valid;
	logic        ready;
	logic [22:0] year_number;
	logic        is_bc;
	logic [3:0]  month_number;
	logic [4:0]  day_of_month;
	logic        order_error;

	modport source(output valid, output year_number, output is_bc, output month_number,
		output day_of_month, output order_error, input ready);
	modport sink(input valid, input year_number, input is_bc, input month_number,
		input day_of_month, input order_error, output ready);
endinterface

[rtl/core/julian_day_calendar_walker.sv]
// Julian day calendar walker: microcoded sequencer and datapath.
// Depends on jdcw_pkg and the channel interfaces in jdcw_if.sv.
//
// Usage: the target channel carries one Julian day number per beat; the
// date channel returns one calendar date per beat (year magnitude, BC flag,
// month, day, order error). Targets must not decrease; a smaller target
// returns the current date unchanged with order_error set.
// The block keeps a running date, starting at 1 January 4713 BC, and walks
// it forward from a small control store: per microcode step it jumps a
// whole 400-year Gregorian cycle, a whole year, the rest of a month, or the
// final days. A target behind the current day goes straight to the emit
// step with order_error set; otherwise the remaining days are walked down
// to zero, and whole 400-year cycles are jumped only from 1 January after
// 1582. One item is in work at a time; the next target is taken once the
// date is placed in the output register, while that register may still
// wait for the receiver. A stalled receiver holds the date and the
// sequencer waits at its emit step.
// Reset clears the running date to 1 January 4713 BC, day counter zero.
module julian_day_calendar_walker (
	input logic          clk,
	input logic          arst_n,
	jdcw_target_if.sink  target,
	jdcw_date_if.source  date
);
	import jdcw_pkg::*;

	// Sequencer and architectural state
	step_t              step_q;
	logic [31:0]        day_count_q;
	logic signed [23:0] year_q;
	logic [8:0]         year_mod_q;
	logic [3:0]         month_q;
	logic [4:0]         day_q;
	logic               leap_q;

	// Work registers
	logic [31:0] tgt_q;
	logic [31:0] rem_q;
	logic        err_q;

	// Output register
	logic        out_v_q;
	logic [22:0] out_year_q;
	logic        out_bc_q;
	logic [3:0]  out_month_q;
	logic [4:0]  out_day_q;
	logic        out_err_q;

	ucode_t             uc;
	logic               hit;
	logic               jan1;
	logic [8:0]         year_len;
	logic [4:0]         dim;
	logic [5:0]         left_days;
	logic signed [23:0] ny;
	logic [8:0]         nmod;
	logic               nleap;
	logic               ncentury;
	logic [23:0]        mag;
	logic [31:0]        shifted;

	// Decode the current control word
	always_comb begin
		uc = ucode_rom(step_q);
	end

	// Calendar datapath terms
	always_comb begin
		jan1      = (month_q == MonthJan) && (day_q == 5'd1);
		year_len  = CommonYearDays + {8'b0, leap_q};
		dim       = month_len(month_q, leap_q);
		left_days = {1'b0, dim} - {1'b0, day_q} + 6'd1;
		shifted   = (target.target_day >= JdReform) ?
			({1'b0, target.target_day} + ReformSkip) : {1'b0, target.target_day};
		mag       = year_q[23] ? 24'(-year_q) : 24'(year_q);
	end

	// Next year: skip year zero, track year mod 400 for the Gregorian rule
	always_comb begin
		if (year_q == -24'sd1) begin
			ny   = 24'sd1;
			nmod = 9'd1;
		end else begin
			ny   = year_q + 24'sd1;
			nmod = (year_mod_q == Mod400Last) ? 9'd0 : year_mod_q + 9'd1;
		end
		ncentury = (nmod == Century1) || (nmod == Century2) || (nmod == Century3);
		if (ny <= LastJulianYear) begin
			nleap = ny[23] ? (ny[1:0] == 2'b11) : (ny[1:0] == 2'b00);
		end else begin
			nleap = (nmod == 9'd0) || (!ncentury && (nmod[1:0] == 2'b00));
		end
	end

	// Evaluate the branch condition
	always_comb begin
		case (uc.cond)
			COND_ALWAYS:   hit = 1'b1;
			COND_IN_VALID: hit = target.valid;
			COND_BEHIND:   hit = tgt_q < day_count_q;
			COND_REM_ZERO: hit = rem_q == 32'd0;
			COND_CYCLE_OK: hit = jan1 && (year_q > LastJulianYear) && (rem_q >= GregCycleDays);
			COND_YEAR_OK:  hit = jan1 && (rem_q >= {23'b0, year_len});
			COND_MONTH_OK: hit = rem_q >= {26'b0, left_days};
			COND_OUT_FREE: hit = !out_v_q || date.ready;
			default:       hit = 1'b0;
		endcase
	end

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= hit ? uc.jump_t : uc.jump_f;
		end
	end

	// Update the running date
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_count_q <= 32'd0;
			year_q      <= StartYear;
			year_mod_q  <= 9'd0;
			month_q     <= MonthJan;
			day_q       <= 5'd1;
			leap_q      <= 1'b1;
		end else if (hit) begin
			case (uc.op)
				OP_LOAD: begin
					day_count_q <= tgt_q;
				end
				OP_CYCLE: begin
					year_q <= year_q + GregCycleYears;
				end
				OP_YEAR: begin
					year_q     <= ny;
					year_mod_q <= nmod;
					leap_q     <= nleap;
				end
				OP_MONTH: begin
					day_q <= 5'd1;
					if (month_q >= MonthDec) begin
						month_q    <= MonthJan;
						year_q     <= ny;
						year_mod_q <= nmod;
						leap_q     <= nleap;
					end else begin
						month_q <= month_q + 4'd1;
					end
				end
				OP_DAY: begin
					day_q <= day_q + rem_q[4:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Hold the target, remaining days and error flag of the item in work
	always_ff @(posedge clk) begin
		if (hit) begin
			case (uc.op)
				OP_ACCEPT: begin
					tgt_q <= shifted;
					err_q <= 1'b0;
				end
				OP_FLAG_ERR: err_q <= 1'b1;
				OP_LOAD:     rem_q <= tgt_q - day_count_q;
				OP_CYCLE:    rem_q <= rem_q - GregCycleDays;
				OP_YEAR:     rem_q <= rem_q - {23'b0, year_len};
				OP_MONTH:    rem_q <= rem_q - {26'b0, left_days};
				OP_DAY:      rem_q <= 32'd0;
				default: begin
				end
			endcase
		end
	end

	// Output beat valid: set on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (hit && (uc.op == OP_EMIT)) begin
			out_v_q <= 1'b1;
		end else if (date.ready) begin
			out_v_q <= 1'b0;
		end
	end

	// Capture the date into the output register
	always_ff @(posedge clk) begin
		if (hit && (uc.op == OP_EMIT)) begin
			out_year_q  <= mag[22:0];
			out_bc_q    <= year_q[23];
			out_month_q <= month_q;
			out_day_q   <= day_q;
			out_err_q   <= err_q;
		end
	end

	assign target.ready      = (uc.op == OP_ACCEPT);
	assign date.valid        = out_v_q;
	assign date.year_number  = out_year_q;
	assign date.is_bc        = out_bc_q;
	assign date.month_number = out_month_q;
	assign date.day_of_month = out_day_q;
	assign date.order_error  = out_err_q;

endmodule

[rtl/core/jdcw_check.sv]
// Port-level checks for the Julian day calendar walker, bound to the top
// level. Depends on jdcw_pkg and julian_day_calendar_walker.
module jdcw_check (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [22:0] year_number,
	input logic [3:0]  month_number,
	input logic [4:0]  day_of_month
);
	import jdcw_pkg::*;

	// A stalled date beat stays and holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(month_number)
		&& $stable(day_of_month) && $stable(year_number))
		else $error("date beat dropped or changed while stalled");

	// One target at a time: no new beat right after one is taken
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("target taken while another is in work");

	// Month stays a real calendar month
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (month_number >= MonthJan) && (month_number <= MonthDec))
		else $error("month out of range");

	// Day and year are never zero
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (day_of_month != 5'd0) && (year_number != 23'd0))
		else $error("zero day or year on date beat");

endmodule

bind julian_day_calendar_walker jdcw_check u_jdcw_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (target.valid),
	.in_ready     (target.ready),
	.out_valid    (date.valid),
	.out_ready    (date.ready),
	.year_number  (date.year_number),
	.month_number (date.month_number),
	.day_of_month (date.day_of_month)
);
